FILE: rtl/core/fcus_pkg.sv
// Types, constants, microcode program and math helpers of the folded cubic shaper.
`default_nettype none

package fcus_pkg;

    localparam int PC_W = 6;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_BASE_OCTAVE = 3'd0;
    localparam logic [2:0] REG_HYST_DB     = 3'd1;
    localparam logic [2:0] REG_PLANK_GAIN  = 3'd2;
    localparam logic [2:0] REG_NEWTON_GAIN = 3'd3;
    localparam logic [2:0] REG_MASS_GAIN   = 3'd4;
    localparam logic [2:0] REG_ANGLE_GAIN  = 3'd5;
    localparam logic [2:0] REG_SAMPLE_RATE = 3'd6;

    localparam logic [13:0] PLANK_RESET = 14'd4096;
    localparam logic [14:0] MASS_RESET  = 15'd8192;
    localparam logic [17:0] FS_RESET    = 18'd44100;

    localparam logic signed [63:0] Q_ONE  = 64'sd65536;
    localparam logic signed [63:0] Q_MAX  = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN  = -64'sd2147483648;
    localparam logic signed [63:0] C4_Q16 = 64'sd17145893;

    localparam logic [17:0] EXP_TAB [17] = '{
        18'd65536, 18'd68438, 18'd71468, 18'd74632, 18'd77936, 18'd81386,
        18'd84990, 18'd88752, 18'd92682, 18'd96785, 18'd101070, 18'd105545,
        18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
    };

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_FMUL, OP_MUL, OP_SHL16, OP_POW2, OP_DIVF, OP_DIVT,
        OP_SQRT, OP_LDPH, OP_STPH, OP_EXTT, OP_EXTW, OP_JLT, OP_OUT
    } t_op;

    typedef enum logic [4:0] {
        SRC_R0, SRC_R1, SRC_R2, SRC_R3, SRC_R4, SRC_R5, SRC_R6, SRC_R7,
        SRC_EBASE, SRC_EHYST, SRC_PC32, SRC_NC32, SRC_MC32,
        SRC_PLANK16, SRC_NEWTON16, SRC_MASS16, SRC_EANGLE, SRC_SIG8,
        SRC_FS, SRC_C4, SRC_K30, SRC_K10, SRC_K20, SRC_K6, SRC_ONE, SRC_ZERO
    } t_src;

    typedef struct packed {
        t_op             op;
        logic [2:0]      dst;
        t_src            src_a;
        t_src            src_b;
        logic            sat;
        logic [PC_W-1:0] tgt;
    } t_uop;

    localparam logic [PC_W-1:0] LAST_PC = 6'd46;

    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        u = '{OP_OUT, 3'd3, SRC_R3, SRC_ZERO, 1'b0, 6'd0};
        case (pc)
            6'd0:  u = '{OP_POW2,  3'd0, SRC_EBASE,   SRC_ZERO, 1'b0, 6'd0};
            6'd1:  u = '{OP_FMUL,  3'd0, SRC_R0,      SRC_C4,   1'b0, 6'd0};
            6'd2:  u = '{OP_SHL16, 3'd0, SRC_R0,      SRC_ZERO, 1'b0, 6'd0};
            6'd3:  u = '{OP_DIVT,  3'd0, SRC_R0,      SRC_FS,   1'b0, 6'd0};
            6'd4:  u = '{OP_LDPH,  3'd1, SRC_ZERO,    SRC_ZERO, 1'b0, 6'd0};
            6'd5:  u = '{OP_ADD,   3'd1, SRC_R1,      SRC_R0,   1'b0, 6'd0};
            6'd6:  u = '{OP_STPH,  3'd0, SRC_R1,      SRC_ZERO, 1'b0, 6'd0};
            6'd7:  u = '{OP_EXTT,  3'd2, SRC_R1,      SRC_ZERO, 1'b0, 6'd0};
            6'd8:  u = '{OP_EXTW,  3'd3, SRC_R1,      SRC_ZERO, 1'b0, 6'd0};
            6'd9:  u = '{OP_SUB,   3'd4, SRC_R2,      SRC_ONE,  1'b0, 6'd0};
            6'd10: u = '{OP_FMUL,  3'd4, SRC_R2,      SRC_R4,   1'b0, 6'd0};
            6'd11: u = '{OP_FMUL,  3'd4, SRC_R4,      SRC_R3,   1'b0, 6'd0};
            6'd12: u = '{OP_MUL,   3'd4, SRC_R4,      SRC_K20,  1'b0, 6'd0};
            6'd13: u = '{OP_DIVF,  3'd5, SRC_EHYST,   SRC_K30,  1'b0, 6'd0};
            6'd14: u = '{OP_SUB,   3'd5, SRC_R5,      SRC_ONE,  1'b0, 6'd0};
            6'd15: u = '{OP_POW2,  3'd5, SRC_R5,      SRC_ZERO, 1'b0, 6'd0};
            6'd16: u = '{OP_JLT,   3'd0, SRC_R4,      SRC_R5,   1'b0, 6'd19};
            6'd17: u = '{OP_MUL,   3'd6, SRC_R5,      SRC_R5,   1'b0, 6'd0};
            6'd18: u = '{OP_DIVT,  3'd4, SRC_R6,      SRC_R4,   1'b1, 6'd0};
            6'd19: u = '{OP_DIVF,  3'd6, SRC_PC32,    SRC_K10,  1'b0, 6'd0};
            6'd20: u = '{OP_ADD,   3'd6, SRC_R6,      SRC_PLANK16, 1'b0, 6'd0};
            6'd21: u = '{OP_POW2,  3'd6, SRC_R6,      SRC_ZERO, 1'b0, 6'd0};
            6'd22: u = '{OP_FMUL,  3'd4, SRC_R4,      SRC_R6,   1'b1, 6'd0};
            6'd23: u = '{OP_FMUL,  3'd6, SRC_R4,      SRC_R4,   1'b1, 6'd0};
            6'd24: u = '{OP_POW2,  3'd7, SRC_EANGLE,  SRC_ZERO, 1'b0, 6'd0};
            6'd25: u = '{OP_FMUL,  3'd6, SRC_R6,      SRC_R7,   1'b1, 6'd0};
            6'd26: u = '{OP_ADD,   3'd6, SRC_R6,      SRC_ONE,  1'b1, 6'd0};
            6'd27: u = '{OP_SQRT,  3'd6, SRC_R6,      SRC_ZERO, 1'b0, 6'd0};
            6'd28: u = '{OP_FMUL,  3'd2, SRC_SIG8,    SRC_R6,   1'b1, 6'd0};
            6'd29: u = '{OP_DIVF,  3'd6, SRC_NC32,    SRC_K10,  1'b0, 6'd0};
            6'd30: u = '{OP_ADD,   3'd6, SRC_R6,      SRC_NEWTON16, 1'b0, 6'd0};
            6'd31: u = '{OP_POW2,  3'd6, SRC_R6,      SRC_ZERO, 1'b0, 6'd0};
            6'd32: u = '{OP_FMUL,  3'd7, SRC_R2,      SRC_R2,   1'b1, 6'd0};
            6'd33: u = '{OP_FMUL,  3'd7, SRC_R7,      SRC_R6,   1'b1, 6'd0};
            6'd34: u = '{OP_FMUL,  3'd7, SRC_R7,      SRC_R4,   1'b1, 6'd0};
            6'd35: u = '{OP_ADD,   3'd3, SRC_R4,      SRC_R7,   1'b1, 6'd0};
            6'd36: u = '{OP_MUL,   3'd2, SRC_R2,      SRC_K6,   1'b1, 6'd0};
            6'd37: u = '{OP_JLT,   3'd0, SRC_R2,      SRC_R5,   1'b0, 6'd40};
            6'd38: u = '{OP_MUL,   3'd6, SRC_R5,      SRC_R5,   1'b0, 6'd0};
            6'd39: u = '{OP_DIVT,  3'd2, SRC_R6,      SRC_R2,   1'b1, 6'd0};
            6'd40: u = '{OP_DIVF,  3'd6, SRC_MC32,    SRC_K10,  1'b0, 6'd0};
            6'd41: u = '{OP_ADD,   3'd6, SRC_R6,      SRC_MASS16, 1'b0, 6'd0};
            6'd42: u = '{OP_POW2,  3'd6, SRC_R6,      SRC_ZERO, 1'b0, 6'd0};
            6'd43: u = '{OP_FMUL,  3'd6, SRC_R6,      SRC_R4,   1'b1, 6'd0};
            6'd44: u = '{OP_FMUL,  3'd6, SRC_R6,      SRC_R2,   1'b1, 6'd0};
            6'd45: u = '{OP_ADD,   3'd3, SRC_R3,      SRC_R6,   1'b1, 6'd0};
            default: u = '{OP_OUT, 3'd3, SRC_R3,      SRC_ZERO, 1'b0, 6'd0};
        endcase
        return u;
    endfunction

    function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > Q_MAX) r = Q_MAX;
        if (v < Q_MIN) r = Q_MIN;
        return r;
    endfunction

    // 2^e, Q16.16 in and out, table with linear interpolation
    function automatic logic signed [63:0] pow2_q(input logic signed [63:0] e);
        logic signed [47:0] ip;
        logic [3:0]         k;
        logic [11:0]        fr;
        logic [17:0]        t0;
        logic [17:0]        t1;
        logic [24:0]        dm;
        logic [17:0]        m;
        logic [5:0]         nsh;
        logic signed [63:0] r;
        ip = e[63:16];
        k  = e[15:12];
        fr = e[11:0];
        t0 = EXP_TAB[k];
        t1 = EXP_TAB[5'({1'b0, k}) + 5'd1];
        dm = 25'(t1 - t0) * 25'(fr);
        m  = t0 + 18'(dm >> 12);
        nsh = 6'(-ip);
        if (ip >= 48'sd15) begin
            r = Q_MAX;
        end else if (ip <= -48'sd18) begin
            r = 64'sd0;
        end else if (ip >= 48'sd0) begin
            r = sat32($signed({46'd0, m} << ip[3:0]));
        end else begin
            r = $signed({46'd0, m} >> nsh);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/folded_cubic_uncertainty_shaper_top.sv
// Folded cubic uncertainty shaper: microcoded sequencer over a shared datapath.
// Each request runs 43 to 47 program steps, with one to three serial divides and one square root.
// Throughput: one request at a time; the next request is taken the cycle after the result
// is latched; a stalled result holds the program end.
// Reset (i_rst_n low, synchronous) clears control state and phase valid bits and loads configuration defaults.
`default_nettype none

module folded_cubic_uncertainty_shaper_top
    import fcus_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [17:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [3:0]         i_channel,
    input  wire logic signed [15:0] i_signal_in,
    input  wire logic signed [15:0] i_omega_cv,
    input  wire logic signed [15:0] i_hyst_cv,
    input  wire logic signed [15:0] i_plank_cv,
    input  wire logic signed [15:0] i_newton_cv,
    input  wire logic signed [15:0] i_mass_cv,
    input  wire logic signed [15:0] i_angle_cv,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [3:0]              o_channel_out,
    output logic signed [15:0]      o_signal_out
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // reciprocals of 10 and 30, scaled by 2^27 and 2^28
    localparam logic [23:0] DIV10_RECIP = 24'd13421773;
    localparam logic [23:0] DIV30_RECIP = 24'd8947849;

    // configuration
    logic signed [15:0] r_base_octave;
    logic [14:0]        r_hyst_db;
    logic [13:0]        r_plank_gain;
    logic [13:0]        r_newton_gain;
    logic [14:0]        r_mass_gain;
    logic signed [13:0] r_angle_gain;
    logic [17:0]        r_fs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_octave <= '0;
            r_hyst_db     <= '0;
            r_plank_gain  <= PLANK_RESET;
            r_newton_gain <= '0;
            r_mass_gain   <= MASS_RESET;
            r_angle_gain  <= '0;
            r_fs          <= FS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BASE_OCTAVE: r_base_octave <= i_cfg_data[15:0];
                REG_HYST_DB:     r_hyst_db     <= i_cfg_data[14:0];
                REG_PLANK_GAIN:  r_plank_gain  <= i_cfg_data[13:0];
                REG_NEWTON_GAIN: r_newton_gain <= i_cfg_data[13:0];
                REG_MASS_GAIN:   r_mass_gain   <= i_cfg_data[14:0];
                REG_ANGLE_GAIN:  r_angle_gain  <= i_cfg_data[13:0];
                REG_SAMPLE_RATE: r_fs          <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // channel to phase slot map
    logic [IDX_W-1:0] w_idx_map [16];
    for (genvar j = 0; j < 16; j++) begin : g_map
        localparam int SLOT = j % CHANNELS;
        assign w_idx_map[j] = IDX_W'(SLOT);
    end

    // sequencer state
    t_state          r_state, n_state;
    logic [PC_W-1:0] r_pc;
    logic            r_exe;
    t_uop            r_uop;
    t_uop            w_dec;
    logic            r_busy;
    logic            r_done;
    logic            r_is_sqrt;
    logic [5:0]      r_cnt;

    // latched request
    logic [3:0]         r_channel;
    logic [IDX_W-1:0]   r_idx;
    logic signed [15:0] r_sig, r_om, r_hc, r_pc_cv, r_nc, r_mc, r_ac;

    // output register
    logic               r_out_vld;
    logic [3:0]         r_out_ch;
    logic signed [15:0] r_out_sig;

    // phase store
    logic [31:0]         r_ph_mem [CHANNELS];
    logic [CHANNELS-1:0] r_ph_vld;
    logic [31:0]         r_ph_rd;
    logic                r_ph_rdv;

    // register file and operands
    logic signed [63:0] r_rf [8];
    logic signed [63:0] r_rfa, r_rfb, r_ka, r_kb;
    logic               r_a_reg, r_b_reg;

    // divider and square root
    logic [62:0] r_dv_n;
    logic [62:0] r_dv_q;
    logic [31:0] r_dv_d;
    logic [31:0] r_dv_rem;
    logic        r_dv_neg;
    logic [47:0] r_sq_v;
    logic [26:0] r_sq_rem;
    logic [23:0] r_sq_root;

    logic               w_accept;
    logic               w_is_multi;
    logic               w_step_done;
    logic               w_start;
    logic               w_jump;
    logic               w_wr_en;
    logic signed [63:0] w_a, w_b, w_a_abs, w_b_abs;
    logic signed [63:0] w_prod;
    logic signed [63:0] w_res, w_res_s;
    logic signed [63:0] w_dv_res, w_dv_qs;
    logic signed [63:0] w_y;
    logic signed [15:0] w_y16;
    logic [32:0]        w_dv_rem2;
    logic [26:0]        w_sq_rem2;
    logic [26:0]        w_sq_trial;
    logic               w_div30;
    logic [23:0]        w_dc_mag;
    logic [47:0]        w_dc_prod;
    logic [23:0]        w_dc_q;
    logic signed [63:0] w_dc_res;

    function automatic logic signed [63:0] src_val(input t_src s,
        input logic signed [15:0] base, input logic [14:0] hyst,
        input logic [13:0] plank, input logic [13:0] newton,
        input logic [14:0] mass, input logic signed [13:0] angle,
        input logic [17:0] fs, input logic signed [15:0] sig,
        input logic signed [15:0] om, input logic signed [15:0] hc,
        input logic signed [15:0] pc, input logic signed [15:0] nc,
        input logic signed [15:0] mc, input logic signed [15:0] ac);
        logic signed [63:0] v;
        case (s)
            SRC_EBASE:    v = (64'(base) <<< 4) + (64'(om) <<< 5);
            SRC_EHYST:    v = $signed({49'd0, hyst}) * 64'sd80 + 64'(hc) * 64'sd96;
            SRC_PC32:     v = 64'(pc) <<< 5;
            SRC_NC32:     v = 64'(nc) <<< 5;
            SRC_MC32:     v = 64'(mc) <<< 5;
            SRC_PLANK16:  v = $signed({50'd0, plank}) <<< 4;
            SRC_NEWTON16: v = $signed({50'd0, newton}) <<< 4;
            SRC_MASS16:   v = $signed({49'd0, mass}) <<< 4;
            SRC_EANGLE:   v = (64'(angle) <<< 4) + (64'(ac) <<< 5);
            SRC_SIG8:     v = 64'(sig) <<< 3;
            SRC_FS:       v = (fs == 18'd0) ? 64'sd1 : $signed({46'd0, fs});
            SRC_C4:       v = C4_Q16;
            SRC_K30:      v = 64'sd30;
            SRC_K10:      v = 64'sd10;
            SRC_K20:      v = 64'sd20;
            SRC_K6:       v = 64'sd6;
            SRC_ONE:      v = Q_ONE;
            default:      v = 64'sd0;
        endcase
        return v;
    endfunction

    assign w_accept = i_valid && !o_stall;
    assign w_dec    = uop_rom(r_pc);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_RUN;
            ST_RUN:  if (w_step_done && r_uop.op == OP_OUT) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: o_stall = 1'b0;
            default: o_stall = 1'b1;
        endcase
    end

    assign o_valid       = r_out_vld;
    assign o_channel_out = r_out_ch;
    assign o_signal_out  = r_out_sig;

    // datapath
    assign w_a     = r_a_reg ? r_rfa : r_ka;
    assign w_b     = r_b_reg ? r_rfb : r_kb;
    assign w_a_abs = w_a[63] ? -w_a : w_a;
    assign w_b_abs = w_b[63] ? -w_b : w_b;
    assign w_prod  = $signed(w_a[31:0]) * $signed(w_b[31:0]);

    assign w_dv_qs  = r_dv_neg ? -$signed({1'b0, r_dv_q}) : $signed({1'b0, r_dv_q});
    assign w_dv_res = (r_dv_d == 32'd0) ? 64'sd0 : w_dv_qs;

    // floor divide by 10 or 30: a negative dividend goes through ~a and back
    assign w_div30   = (r_uop.src_b == SRC_K30);
    assign w_dc_mag  = w_a[63] ? ~w_a[23:0] : w_a[23:0];
    assign w_dc_prod = w_dc_mag * (w_div30 ? DIV30_RECIP : DIV10_RECIP);
    assign w_dc_q    = w_div30 ? {4'd0, w_dc_prod[47:28]} : {3'd0, w_dc_prod[47:27]};
    assign w_dc_res  = w_a[63] ? ~$signed({40'd0, w_dc_q}) : $signed({40'd0, w_dc_q});

    assign w_y   = w_a >>> 6;
    assign w_y16 = (w_y > 64'sd32767) ? 16'sd32767 :
                   (w_y < -64'sd32768) ? -16'sd32768 : w_y[15:0];

    always_comb begin
        case (r_uop.op)
            OP_ADD:   w_res = w_a + w_b;
            OP_SUB:   w_res = w_a - w_b;
            OP_FMUL:  w_res = w_prod >>> 16;
            OP_MUL:   w_res = w_prod;
            OP_SHL16: w_res = w_a <<< 16;
            OP_POW2:  w_res = pow2_q(w_a);
            OP_DIVF:  w_res = w_dc_res;
            OP_DIVT:  w_res = w_dv_res;
            OP_SQRT:  w_res = $signed({40'd0, r_sq_root});
            OP_LDPH:  w_res = r_ph_rdv ? $signed({32'd0, r_ph_rd}) : 64'sd0;
            OP_EXTT:  w_res = $signed({48'd0, w_a[30:15]});
            OP_EXTW:  w_res = $signed({47'd0, w_a[31:15]}) - Q_ONE;
            default:  w_res = 64'sd0;
        endcase
    end

    assign w_res_s    = r_uop.sat ? sat32(w_res) : w_res;
    assign w_is_multi = (r_uop.op == OP_DIVT) || (r_uop.op == OP_SQRT);
    assign w_start    = r_exe && w_is_multi && !r_busy && !r_done;
    assign w_step_done = r_exe && (w_is_multi ? r_done :
                         (r_uop.op == OP_OUT) ? !(r_out_vld && i_stall) : 1'b1);
    assign w_jump     = (r_uop.op == OP_JLT) && (w_a_abs < w_b);
    assign w_wr_en    = w_step_done && (r_uop.op != OP_STPH) &&
                        (r_uop.op != OP_JLT) && (r_uop.op != OP_OUT);

    assign w_dv_rem2  = {r_dv_rem, r_dv_n[62]};
    assign w_sq_rem2  = {r_sq_rem[24:0], r_sq_v[47:46]};
    assign w_sq_trial = {1'b0, r_sq_root, 2'b01};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pc      <= '0;
            r_exe     <= 1'b0;
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_out_vld <= 1'b0;
            r_ph_vld  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_RUN && w_step_done && r_uop.op == OP_OUT) begin
                r_out_vld <= 1'b1;
            end else if (o_valid && !i_stall) begin
                r_out_vld <= 1'b0;
            end
            if (w_accept) begin
                r_pc  <= '0;
                r_exe <= 1'b0;
            end else if (r_state == ST_RUN) begin
                if (!r_exe) begin
                    r_exe <= 1'b1;
                end else if (w_step_done) begin
                    r_exe  <= 1'b0;
                    r_done <= 1'b0;
                    r_pc   <= w_jump ? r_uop.tgt : r_pc + 1'b1;
                    if (r_uop.op == OP_STPH) r_ph_vld[r_idx] <= 1'b1;
                end
            end
            if (w_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // payload, operands, units
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_channel <= i_channel;
            r_idx     <= w_idx_map[i_channel];
            r_sig     <= i_signal_in;
            r_om      <= i_omega_cv;
            r_hc      <= i_hyst_cv;
            r_pc_cv   <= i_plank_cv;
            r_nc      <= i_newton_cv;
            r_mc      <= i_mass_cv;
            r_ac      <= i_angle_cv;
        end
        r_ph_rd  <= r_ph_mem[r_idx];
        r_ph_rdv <= r_ph_vld[r_idx];
        if (r_state == ST_RUN && !r_exe) begin
            r_uop   <= w_dec;
            r_rfa   <= r_rf[3'(w_dec.src_a)];
            r_rfb   <= r_rf[3'(w_dec.src_b)];
            r_a_reg <= w_dec.src_a <= SRC_R7;
            r_b_reg <= w_dec.src_b <= SRC_R7;
            r_ka    <= src_val(w_dec.src_a, r_base_octave, r_hyst_db,
                               r_plank_gain, r_newton_gain, r_mass_gain, r_angle_gain,
                               r_fs, r_sig, r_om, r_hc, r_pc_cv, r_nc, r_mc, r_ac);
            r_kb    <= src_val(w_dec.src_b, r_base_octave, r_hyst_db,
                               r_plank_gain, r_newton_gain, r_mass_gain, r_angle_gain,
                               r_fs, r_sig, r_om, r_hc, r_pc_cv, r_nc, r_mc, r_ac);
        end
        if (w_wr_en) r_rf[r_uop.dst] <= w_res_s;
        if (w_step_done && r_uop.op == OP_STPH) r_ph_mem[r_idx] <= w_a[31:0];
        if (w_step_done && r_uop.op == OP_OUT) begin
            r_out_ch  <= r_channel;
            r_out_sig <= w_y16;
        end
        if (w_start) begin
            r_is_sqrt  <= (r_uop.op == OP_SQRT);
            r_cnt      <= (r_uop.op == OP_SQRT) ? 6'd23 : 6'd62;
            r_dv_n     <= w_a_abs[62:0];
            r_dv_d     <= w_b_abs[31:0];
            r_dv_q     <= '0;
            r_dv_rem   <= '0;
            r_dv_neg   <= w_a[63] ^ w_b[63];
            r_sq_v     <= {w_a[31:0], 16'd0};
            r_sq_rem   <= '0;
            r_sq_root  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_is_sqrt) begin
                r_sq_v <= r_sq_v << 2;
                if (w_sq_rem2 >= w_sq_trial) begin
                    r_sq_rem  <= w_sq_rem2 - w_sq_trial;
                    r_sq_root <= {r_sq_root[22:0], 1'b1};
                end else begin
                    r_sq_rem  <= w_sq_rem2;
                    r_sq_root <= {r_sq_root[22:0], 1'b0};
                end
            end else begin
                r_dv_n <= r_dv_n << 1;
                if (w_dv_rem2 >= {1'b0, r_dv_d}) begin
                    r_dv_rem <= 32'(w_dv_rem2 - {1'b0, r_dv_d});
                    r_dv_q   <= {r_dv_q[61:0], 1'b1};
                end else begin
                    r_dv_rem <= w_dv_rem2[31:0];
                    r_dv_q   <= {r_dv_q[61:0], 1'b0};
                end
            end
        end
    end

    a_busy_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_state == ST_RUN)
        else $error("iterative unit busy outside a request");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("unit done while still busy");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> r_pc <= LAST_PC)
        else $error("step counter past end of program");

    a_out_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state) == ST_RUN && r_state == ST_IDLE)
        else $error("result latched outside the program end");

endmodule

`default_nettype wire
